[sv/b64_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b64_pkg: shared types and helpers for the Base64 stream codec
// Holds the result-group descriptor, register indexes and alphabet functions.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Configuration register indexes.
    localparam logic [1:0] REG_DECODE_MODE = 2'd0;
    localparam logic [1:0] REG_URL_SAFE    = 2'd1;

    // Result-group queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One group of one to four results caused by a single input transaction.
    typedef struct packed {
        logic [3:0][7:0] bytes;      // bytes[0] goes out first
        logic [2:0]      count;      // number of results, 1 to 4
        logic            data;       // 0 for a bare end marker
        logic            stream_end; // last group of the stream
        logic            bad;        // decode failure, on stream end only
    } job_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v, input logic url);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = url ? 8'h2D : 8'h2B;
        end else begin
            c = url ? 8'h5F : 8'h2F;
        end
        return c;
    endfunction

    // Returns {valid, sextet}.
    function automatic logic [6:0] dec_char(input logic [7:0] c, input logic url);
        logic [7:0] t;
        logic [6:0] r;
        t = 8'h00;
        r = 7'h00;
        if (c inside {[8'h41:8'h5A]}) begin
            t = c - 8'h41;
            r = {1'b1, t[5:0]};
        end else if (c inside {[8'h61:8'h7A]}) begin
            t = c - 8'h61 + 8'd26;
            r = {1'b1, t[5:0]};
        end else if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30 + 8'd52;
            r = {1'b1, t[5:0]};
        end else if (url && c == 8'h2D) begin
            r = {1'b1, 6'd62};
        end else if (url && c == 8'h5F) begin
            r = {1'b1, 6'd63};
        end else if (!url && c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (!url && c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/b64_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b64_front: input side of the Base64 stream codec
// Holds the registers and the group state, and turns each input transaction
// into at most one group descriptor for the queue.
// ----------------------------------------------------------------------------
module b64_front
    import b64_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic       cfg_data,
    input  wire logic       q_full,
    output logic            q_push,
    output job_t            q_job
);

    logic        decode_reg, url_reg;
    logic [23:0] gb_reg, gb_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  pads_reg, pads_next;
    logic        err_reg, err_next;
    logic        acc;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign acc       = s_tvalid && !q_full;

    always_comb begin
        logic [23:0] a;
        logic [23:0] gfull;
        logic [6:0]  dv;
        logic [2:0]  c;
        logic [2:0]  n;
        logic        ok;
        gb_next   = gb_reg;
        cnt_next  = cnt_reg;
        pads_next = pads_reg;
        err_next  = err_reg;
        q_job     = '0;
        n         = 3'd0;
        a         = 24'h0;
        gfull     = {gb_reg[17:0], 6'h00};
        dv        = 7'h00;
        c         = 3'd0;
        ok        = 1'b0;
        if (!decode_reg) begin
            a = {gb_reg[15:0], s_tdata};
            if (cnt_reg == 2'd2) begin
                for (int k = 0; k < 4; k++) begin
                    q_job.bytes[k] = enc_char(a[23 - 6 * k -: 6], url_reg);
                end
                n        = 3'd4;
                gb_next  = 24'h0;
                cnt_next = 2'd0;
            end else begin
                gb_next  = a;
                cnt_next = cnt_reg + 2'd1;
                if (s_tlast) begin
                    // Partial group: left-align the bytes, then pad.
                    c = {1'b0, cnt_reg} + 3'd1;
                    a = (cnt_reg == 2'd0) ? {s_tdata, 16'h0} : {gb_reg[7:0], s_tdata, 8'h0};
                    for (int k = 0; k < 4; k++) begin
                        q_job.bytes[k] = (3'(k) <= c) ? enc_char(a[23 - 6 * k -: 6], url_reg)
                                                      : PAD_CHAR;
                    end
                    n = url_reg ? c + 3'd1 : 3'd4;
                end
            end
        end else if (!err_reg) begin
            if (s_tdata == PAD_CHAR) begin
                if (cnt_reg < 2'd2 || ({1'b0, cnt_reg} + {1'b0, pads_reg}) >= 3'd4) begin
                    err_next = 1'b1;
                end else begin
                    pads_next = pads_reg + 2'd1;
                end
            end else begin
                dv    = dec_char(s_tdata, url_reg);
                gfull = {gb_reg[17:0], dv[5:0]};
                if (!dv[6] || pads_reg != 2'd0) begin
                    err_next = 1'b1;
                end else if (cnt_reg == 2'd3) begin
                    q_job.bytes[0] = gfull[23:16];
                    q_job.bytes[1] = gfull[15:8];
                    q_job.bytes[2] = gfull[7:0];
                    n        = 3'd3;
                    gb_next  = 24'h0;
                    cnt_next = 2'd0;
                end else begin
                    gb_next  = gfull;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            if (s_tlast && !err_next) begin
                c = {1'b0, cnt_next};
                if (pads_next != 2'd0) begin
                    ok = (c + {1'b0, pads_next}) == 3'd4;
                end else if (c == 3'd1) begin
                    ok = 1'b0;
                end else begin
                    ok = (c == 3'd0) || url_reg;
                end
                if (!ok) begin
                    err_next = 1'b1;
                end else if (c >= 3'd2) begin
                    // Trailing bits below the last whole byte are dropped.
                    a = (c == 3'd2) ? {gb_next[11:0], 12'h0} : {gb_next[17:0], 6'h0};
                    q_job.bytes[0] = a[23:16];
                    q_job.bytes[1] = a[15:8];
                    n = c - 3'd1;
                end
            end
        end
        q_job.count = n;
        q_job.data  = 1'b1;
        if (s_tlast) begin
            if (n == 3'd0) begin
                q_job.bytes = '0;
                q_job.count = 3'd1;
                q_job.data  = 1'b0;
            end
            q_job.stream_end = 1'b1;
            q_job.bad        = decode_reg && err_next;
            gb_next   = 24'h0;
            cnt_next  = 2'd0;
            pads_next = 2'd0;
            err_next  = 1'b0;
        end
        q_push = acc && (n != 3'd0 || s_tlast);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_reg <= 1'b0;
            url_reg    <= 1'b0;
            gb_reg     <= 24'h0;
            cnt_reg    <= 2'd0;
            pads_reg   <= 2'd0;
            err_reg    <= 1'b0;
        end else begin
            if (acc) begin
                gb_reg   <= gb_next;
                cnt_reg  <= cnt_next;
                pads_reg <= pads_next;
                err_reg  <= err_next;
            end
            if (cfg_valid && cfg_index == REG_DECODE_MODE) begin
                decode_reg <= cfg_data;
                gb_reg     <= 24'h0;
                cnt_reg    <= 2'd0;
                pads_reg   <= 2'd0;
                err_reg    <= 1'b0;
            end
            if (cfg_valid && cfg_index == REG_URL_SAFE) begin
                url_reg <= cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

[sv/b64_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b64_queue: group descriptor queue
// A small FIFO that lets the front and back ends stall independently.
// ----------------------------------------------------------------------------
module b64_queue
    import b64_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      avail,
    output job_t      head
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign avail = cnt_reg != '0;
    assign head  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

[sv/b64_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// b64_back: output side of the Base64 stream codec
// Takes one group descriptor at a time and sends its results one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module b64_back
    import b64_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_avail,
    input  wire job_t q_head,
    output logic      q_pop,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [2:0] m_tuser
);

    job_t       cur_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       final_beat;

    assign final_beat = ({1'b0, idx_reg} == cur_reg.count - 3'd1);
    assign q_pop      = q_avail && (!busy_reg || (m_tready && final_beat));

    assign m_tvalid = busy_reg;
    assign m_tdata  = cur_reg.bytes[idx_reg];
    assign m_tlast  = final_beat && cur_reg.stream_end;
    assign m_tuser  = {final_beat && cur_reg.bad, final_beat, cur_reg.data};

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (busy_reg && m_tready) begin
            if (final_beat) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule
`default_nettype wire

[sv/base64_stream_codec.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming Base64 encoder and decoder
// Byte stream in, Base64 text or decoded bytes out, standard or URL alphabet.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte and an end flag. With decode_mode
// at 0 the block encodes: every three bytes give four characters, and at the
// end of a stream a partial group is flushed and, with the standard alphabet,
// padded with '=' to four. With decode_mode at 1 it decodes: every four
// characters give three bytes, a final group may end in one or two pads, and
// an unpadded final group of two or three characters is taken only with the
// URL-safe alphabet. A bad character, a misplaced pad or a final group of one
// character sets a sticky error: no more bytes come out and the stream-end
// result reports it. A stream end that causes no byte yields one bare end
// marker. An input transaction is taken whenever the queue has room, and
// results leave at one per cycle while m_tready is high, so in encode mode
// the output port sets the sustained rate. A four-entry queue between the
// input side and the output side lets the input keep flowing while the
// output is stalled. Configuration must be written only while the stream is
// idle; the block does not enforce this. Writing decode_mode clears the stream.
// ----------------------------------------------------------------------------
module base64_stream_codec
    import b64_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // in_last
    // Result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // stream_end
    output logic [2:0]      m_tuser,   // [0] out_valid, [1] run_end, [2] bad_input
    // Configuration writes: index 0 decode_mode, index 1 url_safe_alphabet
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic       cfg_data
);

    logic q_full, q_push, q_pop, q_avail;
    job_t q_job, q_head;

    // The front end classifies each transaction and builds a result group.
    b64_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Groups wait here until the output side is ready for them.
    b64_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head)
    );

    // The back end serializes each group, one result per transaction.
    b64_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_avail  (q_avail),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The stream end is always the last result of its group.
    a_end_is_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("stream end without run end");

    // A decode failure is reported only on the stream-end result.
    a_bad_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("bad_input away from stream end");

    // A bare end marker only closes a stream.
    a_bare_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
        else $error("bare marker not at stream end");

    // A stalled result stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

endmodule
`default_nettype wire
